[src/dsf_pkg.sv]
package dsf_pkg;

    localparam int DEF_MAX_SIDE = 1024;
    localparam int RST_SIDE     = 512;
    localparam int CFG_W        = 11;
    localparam int PIX_W        = 8;

    // Column sum of three pixels and the full 3x3 sums.
    localparam int COL_W = PIX_W + 2;
    localparam int SUM_W = PIX_W + 4;

    // Divide by nine as a multiply by ceil(2^16 / 9) and a shift; exact for every box sum.
    localparam int                BOX_SHIFT  = 16;
    localparam logic [SUM_W:0]    BOX_RECIP  = 13'd7282;
    localparam int                PROD_W     = SUM_W + SUM_W + 1;
    // Divide by sixteen is a shift.
    localparam int                WSUM_SHIFT = 4;

    // Column selection of the 3x3 window, which holds columns 0 (oldest) to 2 (newest).
    typedef enum logic [1:0] {
        SEL_NORM,    // left 0, centre 1, right 2
        SEL_MIRL,    // left edge: left 2, centre 1, right 2
        SEL_EDGE_SH, // right edge after a shift: left 0, centre 1, right 0
        SEL_EDGE     // right edge with no shift: left 1, centre 2, right 1
    } t_sel;

    typedef logic [2:0][PIX_W-1:0] t_col;
    typedef logic [2:0][2:0][PIX_W-1:0] t_win;

    typedef struct packed {
        logic proc;   // word shifts a new column into the window
        logic live;   // row lies inside the image, line stores are updated
        logic first;  // second image row: top row mirrors the current pixel
        logic emit;   // word produces a result
        t_sel sel;
        logic last;
    } t_ctl;

    typedef struct packed {
        t_sel sel;
        logic last;
    } t_emit;

endpackage

[src/dual_3x3_smoothing_filter.sv]
// Smooths a square 8-bit image of side N (the configuration word, clamped to 2..MAX_SIDE,
// 512 after reset) given in raster order, one pixel word per clock, with mirrored borders,
// and returns for every pixel the 3x3 box mean (sum / 9) and the 1-2-1 weighted mean
// (sum / 16), both truncated. The result for pixel k leaves once word k+N+1 has been taken,
// so after the last pixel the source sends N+1 drain words; o_last marks the final result
// and the next pixel then starts a new image. A drain word sent while pixels are still due
// is taken and dropped, and a pixel word after the image counts as a drain word. Writing
// the side restarts the image. Throughput is one word per clock unless the output stalls:
// each of the two line memories (MAX_SIDE x 8, not cleared after reset) takes one read and
// one write per cycle, and a result reaches the output register by way of the window and sum registers.
module dual_3x3_smoothing_filter #(
    parameter int MAX_SIDE = dsf_pkg::DEF_MAX_SIDE
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [dsf_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_mode,
    input  logic [dsf_pkg::PIX_W-1:0] i_pixel,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [dsf_pkg::PIX_W-1:0] o_box_mean,
    output logic [dsf_pkg::PIX_W-1:0] o_weighted_mean,
    output logic                      o_last
);
    import dsf_pkg::*;

    localparam int AW = $clog2(MAX_SIDE);

    logic             cfg_we;
    logic             accept;
    logic             load;
    t_ctl             ctl;
    logic [AW-1:0]    raddr;
    logic             ram_re;
    logic             ram_we;
    logic [AW-1:0]    waddr;
    logic [PIX_W-1:0] wdata_old;
    logic [PIX_W-1:0] wdata_new;
    logic [PIX_W-1:0] rd_old;
    logic [PIX_W-1:0] rd_new;
    logic             take;
    t_win             win;
    logic             emit_valid;
    t_emit            emit;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign ram_re      = load && ctl.proc;

    dsf_ctrl #(
        .MAX_SIDE(MAX_SIDE)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_accept  (accept),
        .i_mode    (i_mode),
        .o_load    (load),
        .o_ctl     (ctl),
        .o_addr    (raddr)
    );

    dsf_ram #(
        .WIDTH(PIX_W),
        .DEPTH(MAX_SIDE)
    ) u_ram_old (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(waddr),
        .i_wdata(wdata_old),
        .i_re   (ram_re),
        .i_raddr(raddr),
        .o_rdata(rd_old)
    );

    dsf_ram #(
        .WIDTH(PIX_W),
        .DEPTH(MAX_SIDE)
    ) u_ram_new (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(waddr),
        .i_wdata(wdata_new),
        .i_re   (ram_re),
        .i_raddr(raddr),
        .o_rdata(rd_new)
    );

    dsf_win #(
        .MAX_SIDE(MAX_SIDE)
    ) u_win (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_ctl       (ctl),
        .i_addr      (raddr),
        .i_pixel     (i_pixel),
        .i_take      (take),
        .i_rd_old    (rd_old),
        .i_rd_new    (rd_new),
        .o_ready     (o_in_ready),
        .o_we        (ram_we),
        .o_waddr     (waddr),
        .o_wdata_old (wdata_old),
        .o_wdata_new (wdata_new),
        .o_win       (win),
        .o_emit_valid(emit_valid),
        .o_emit      (emit)
    );

    dsf_calc u_calc (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_emit_valid   (emit_valid),
        .i_emit         (emit),
        .i_win          (win),
        .o_take         (take),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_box_mean     (o_box_mean),
        .o_weighted_mean(o_weighted_mean),
        .o_last         (o_last)
    );

    // A line store entry is never read in the cycle in which it is written back.
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we && ram_re |-> waddr != raddr)
        else $error("line store read and write hit the same entry");

    // A result leaves the window stage only when the arithmetic stages can hold it.
    a_emit_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_valid |-> take)
        else $error("result word lost between window and arithmetic stages");

    // New words are only taken while the window stage is free to receive line store data.
    a_read_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |=> $past(o_in_ready))
        else $error("line store read issued while window stage was stalled");

endmodule

[src/dsf_ram.sv]
module dsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/dsf_ctrl.sv]
module dsf_ctrl #(
    parameter int MAX_SIDE = dsf_pkg::DEF_MAX_SIDE,
    localparam int SW = $clog2(MAX_SIDE + 2),
    localparam int AW = $clog2(MAX_SIDE)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [dsf_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_accept,
    input  logic                      i_mode,
    output logic                      o_load,
    output dsf_pkg::t_ctl             o_ctl,
    output logic [AW-1:0]             o_addr
);
    import dsf_pkg::*;

    localparam int RST_N = (RST_SIDE > MAX_SIDE) ? MAX_SIDE : RST_SIDE;

    logic [SW-1:0] r_side;
    logic [SW-1:0] r_row;
    logic [SW-1:0] r_col;
    logic [SW-1:0] n_row;
    logic [SW-1:0] n_col;
    logic [SW-1:0] cfg_n;
    logic [SW-1:0] row;
    logic [SW-1:0] col;
    logic          restart;
    logic          ignore;
    logic          pre;
    logic          post;

    // The side register holds the clamped side.
    always_comb begin
        if (i_cfg_data < CFG_W'(2)) begin
            cfg_n = SW'(2);
        end else if (32'(i_cfg_data) > MAX_SIDE) begin
            cfg_n = SW'(MAX_SIDE);
        end else begin
            cfg_n = SW'(i_cfg_data);
        end
    end

    always_comb begin
        restart = (r_col >= r_side) || (r_row > r_side + SW'(1));
        row     = restart ? '0 : r_row;
        col     = restart ? '0 : r_col;
        // A drain word while pixels of the image are still due is dropped.
        ignore  = i_mode && (row < r_side);

        o_ctl.proc  = row <= r_side;
        o_ctl.live  = row < r_side;
        o_ctl.first = row == SW'(1);
        pre         = (col == '0) && (row >= SW'(2));
        post        = o_ctl.proc && (col != '0) && (row != '0);
        o_ctl.emit  = pre || post;
        o_ctl.last  = pre && (row == r_side + SW'(1));
        if (post) begin
            o_ctl.sel = (col == SW'(1)) ? SEL_MIRL : SEL_NORM;
        end else if (o_ctl.proc) begin
            o_ctl.sel = SEL_EDGE_SH;
        end else begin
            o_ctl.sel = SEL_EDGE;
        end

        o_load = i_accept && !ignore;
        o_addr = col[AW-1:0];

        if (o_ctl.last) begin
            n_row = '0;
            n_col = '0;
        end else if (col + SW'(1) >= r_side) begin
            n_row = row + SW'(1);
            n_col = '0;
        end else begin
            n_row = row;
            n_col = col + SW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= SW'(RST_N);
            r_row  <= '0;
            r_col  <= '0;
        end else if (i_cfg_we) begin
            r_side <= cfg_n;
            r_row  <= '0;
            r_col  <= '0;
        end else if (o_load) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

endmodule

[src/dsf_win.sv]
module dsf_win #(
    parameter int MAX_SIDE = dsf_pkg::DEF_MAX_SIDE,
    localparam int AW = $clog2(MAX_SIDE)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_load,
    input  dsf_pkg::t_ctl             i_ctl,
    input  logic [AW-1:0]             i_addr,
    input  logic [dsf_pkg::PIX_W-1:0] i_pixel,
    input  logic                      i_take,
    input  logic [dsf_pkg::PIX_W-1:0] i_rd_old,
    input  logic [dsf_pkg::PIX_W-1:0] i_rd_new,
    output logic                      o_ready,
    output logic                      o_we,
    output logic [AW-1:0]             o_waddr,
    output logic [dsf_pkg::PIX_W-1:0] o_wdata_old,
    output logic [dsf_pkg::PIX_W-1:0] o_wdata_new,
    output dsf_pkg::t_win             o_win,
    output logic                      o_emit_valid,
    output dsf_pkg::t_emit            o_emit
);
    import dsf_pkg::*;

    logic             r_v1;
    t_ctl             r_ctl;
    logic [AW-1:0]    r_addr;
    logic [PIX_W-1:0] r_pix;
    t_win             r_win;
    logic             fire;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;

    assign fire    = r_v1 && i_take;
    assign o_ready = !r_v1 || i_take;

    // Line store data are registered alongside the word and reach the window stage together with it.
    always_comb begin
        if (r_ctl.live) begin
            bot = r_pix;
            mid = i_rd_new;
            top = r_ctl.first ? r_pix : i_rd_old;
        end else begin
            // Row past the bottom edge mirrors the row above the centre.
            top = i_rd_old;
            mid = i_rd_new;
            bot = i_rd_old;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_win <= '0;
        end else begin
            if (o_ready) begin
                r_v1 <= i_load;
            end
            if (fire && r_ctl.proc) begin
                r_win[0]    <= r_win[1];
                r_win[1]    <= r_win[2];
                r_win[2][0] <= top;
                r_win[2][1] <= mid;
                r_win[2][2] <= bot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_ctl  <= i_ctl;
            r_addr <= i_addr;
            r_pix  <= i_pixel;
        end
    end

    assign o_we         = fire && r_ctl.proc && r_ctl.live;
    assign o_waddr      = r_addr;
    assign o_wdata_old  = i_rd_new;
    assign o_wdata_new  = r_pix;
    assign o_win        = r_win;
    assign o_emit_valid = fire && r_ctl.emit;
    assign o_emit.sel   = r_ctl.sel;
    assign o_emit.last  = r_ctl.last;

endmodule

[src/dsf_calc.sv]
module dsf_calc (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_emit_valid,
    input  dsf_pkg::t_emit            i_emit,
    input  dsf_pkg::t_win             i_win,
    output logic                      o_take,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [dsf_pkg::PIX_W-1:0] o_box_mean,
    output logic [dsf_pkg::PIX_W-1:0] o_weighted_mean,
    output logic                      o_last
);
    import dsf_pkg::*;

    logic              r_v2;
    t_emit             r_e2;
    logic              r_v3;
    logic [SUM_W-1:0]  r_box;
    logic [SUM_W-1:0]  r_wsum;
    logic              r_last3;
    logic              r_ov;
    logic [PIX_W-1:0]  r_box_mean;
    logic [PIX_W-1:0]  r_wmean;
    logic              r_olast;
    logic              mv_o;
    logic              en3;
    t_col              cl;
    t_col              cc;
    t_col              cr;
    logic [COL_W-1:0]  sl;
    logic [COL_W-1:0]  sc;
    logic [COL_W-1:0]  sr;
    logic [COL_W-1:0]  wl;
    logic [COL_W-1:0]  wc;
    logic [COL_W-1:0]  wr;
    logic [SUM_W-1:0]  box;
    logic [SUM_W-1:0]  wsum;
    logic [PROD_W-1:0] prod;

    assign mv_o   = !r_ov || i_ready;
    assign en3    = !r_v3 || mv_o;
    assign o_take = !r_v2 || en3;

    always_comb begin
        case (r_e2.sel)
            SEL_NORM: begin
                cl = i_win[0];
                cc = i_win[1];
                cr = i_win[2];
            end
            SEL_MIRL: begin
                cl = i_win[2];
                cc = i_win[1];
                cr = i_win[2];
            end
            SEL_EDGE_SH: begin
                cl = i_win[0];
                cc = i_win[1];
                cr = i_win[0];
            end
            SEL_EDGE: begin
                cl = i_win[1];
                cc = i_win[2];
                cr = i_win[1];
            end
            default: begin
                cl = i_win[0];
                cc = i_win[1];
                cr = i_win[2];
            end
        endcase

        sl = COL_W'(cl[0]) + COL_W'(cl[1]) + COL_W'(cl[2]);
        sc = COL_W'(cc[0]) + COL_W'(cc[1]) + COL_W'(cc[2]);
        sr = COL_W'(cr[0]) + COL_W'(cr[1]) + COL_W'(cr[2]);
        wl = COL_W'(cl[0]) + (COL_W'(cl[1]) << 1) + COL_W'(cl[2]);
        wc = COL_W'(cc[0]) + (COL_W'(cc[1]) << 1) + COL_W'(cc[2]);
        wr = COL_W'(cr[0]) + (COL_W'(cr[1]) << 1) + COL_W'(cr[2]);

        box  = SUM_W'(sl) + SUM_W'(sc) + SUM_W'(sr);
        wsum = SUM_W'(wl) + (SUM_W'(wc) << 1) + SUM_W'(wr);
        prod = PROD_W'(r_box) * PROD_W'(BOX_RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (o_take) begin
                r_v2 <= i_emit_valid;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (mv_o) begin
                r_ov <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_e2 <= i_emit;
        end
        if (en3 && r_v2) begin
            r_box   <= box;
            r_wsum  <= wsum;
            r_last3 <= r_e2.last;
        end
        if (mv_o && r_v3) begin
            r_box_mean <= prod[BOX_SHIFT +: PIX_W];
            r_wmean    <= r_wsum[WSUM_SHIFT +: PIX_W];
            r_olast    <= r_last3;
        end
    end

    assign o_valid         = r_ov;
    assign o_box_mean      = r_box_mean;
    assign o_weighted_mean = r_wmean;
    assign o_last          = r_olast;

endmodule

[sim/smooth_check.sv]
module smooth_check (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_ready,
    input  logic [dsf_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    input  logic                      i_in_ready,
    input  logic                      i_mode,
    input  logic [dsf_pkg::PIX_W-1:0] i_pixel,
    input  logic                      i_out_valid,
    input  logic                      i_out_ready,
    input  logic [dsf_pkg::PIX_W-1:0] i_box_mean,
    input  logic [dsf_pkg::PIX_W-1:0] i_weighted_mean,
    input  logic                      i_last,
    output int                        o_errors,
    output int                        o_awaiting
);
    timeunit 1ns;
    timeprecision 1ps;
    import dsf_pkg::*;

    localparam int MAX_SIDE = DEF_MAX_SIDE;

    typedef struct packed {
        logic [PIX_W-1:0] box;
        logic [PIX_W-1:0] wmean;
        logic             last;
    } t_smoothed;

    t_smoothed        smoothed_q [$];
    logic [CFG_W-1:0] side_reg;
    logic [PIX_W-1:0] row_older [MAX_SIDE];
    logic [PIX_W-1:0] row_newer [MAX_SIDE];
    // Window entries are column * 3 + row, column 0 the oldest, row 0 the top.
    logic [PIX_W-1:0] win [9];
    int unsigned      row_pos;
    int unsigned      col_pos;
    int unsigned      out_pos;
    int               errors = 0;

    function automatic int unsigned side_clamped();
        int unsigned n;
        n = side_reg;
        if (n < 2) n = 2;
        if (n > MAX_SIDE) n = MAX_SIDE;
        return n;
    endfunction

    function automatic void restart_image();
        row_pos = 0;
        col_pos = 0;
        out_pos = 0;
    endfunction

    // Both means from window columns a (left), b (centre) and c (right).
    function automatic void push_means(input int unsigned a, input int unsigned b,
                                       input int unsigned c, input int unsigned total);
        int unsigned cols [3];
        int unsigned box;
        int unsigned wsum;
        int unsigned v;
        int unsigned w;
        int          i;
        int          j;
        t_smoothed   res;
        cols[0] = a;
        cols[1] = b;
        cols[2] = c;
        box  = 0;
        wsum = 0;
        for (i = 0; i < 3; i++) begin
            for (j = 0; j < 3; j++) begin
                v = win[cols[i] * 3 + j];
                w = ((i == 1) ? 2 : 1) * ((j == 1) ? 2 : 1);
                box  += v;
                wsum += v * w;
            end
        end
        res.box   = PIX_W'(box / 9);
        res.wmean = PIX_W'(wsum / 16);
        res.last  = (out_pos + 1 == total);
        out_pos++;
        smoothed_q.push_back(res);
    endfunction

    function automatic void filter_word(input logic is_drain, input logic [PIX_W-1:0] pix);
        int unsigned      n;
        int unsigned      total;
        int unsigned      r;
        int unsigned      c;
        int               k;
        logic             in_img;
        logic             produced;
        logic [PIX_W-1:0] top_px;
        logic [PIX_W-1:0] mid_px;
        logic [PIX_W-1:0] bot_px;
        n        = side_clamped();
        total    = n * n;
        r        = row_pos;
        c        = col_pos;
        in_img   = (r < n);
        produced = 1'b0;
        if (c >= n || r > n + 1) begin
            restart_image();
            r      = 0;
            c      = 0;
            in_img = 1'b1;
        end
        // A drain word while pixels are still due changes nothing.
        if (is_drain && in_img) return;
        // The right-edge result of the previous centre row comes from the old window.
        if (c == 0 && r >= 2) begin
            push_means(1, 2, 1, total);
            produced = 1'b1;
        end
        if (r <= n) begin
            if (r < n) begin
                bot_px       = pix;
                mid_px       = row_newer[c];
                top_px       = (r == 1) ? pix : row_older[c];
                row_older[c] = row_newer[c];
                row_newer[c] = pix;
            end else begin
                // Row past the bottom: the mirrored row is the one above the last.
                top_px = row_older[c];
                mid_px = row_newer[c];
                bot_px = top_px;
            end
            for (k = 0; k < 6; k++) win[k] = win[k + 3];
            win[6] = top_px;
            win[7] = mid_px;
            win[8] = bot_px;
            if (c >= 1 && r >= 1) begin
                if (c == 1) push_means(2, 1, 2, total);
                else push_means(0, 1, 2, total);
                produced = 1'b1;
            end
        end
        if (produced && out_pos >= total) begin
            restart_image();
            return;
        end
        c++;
        if (c >= n) begin
            c = 0;
            r++;
        end
        row_pos = r & 32'h7FF;
        col_pos = c & 32'h7FF;
    endfunction

    function automatic void check_result();
        t_smoothed want;
        if (smoothed_q.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("%0t: result with none due: box %0d weighted %0d last %0b",
                         $realtime, i_box_mean, i_weighted_mean, i_last);
            return;
        end
        want = smoothed_q.pop_front();
        if (i_box_mean !== want.box || i_weighted_mean !== want.wmean
                || i_last !== want.last) begin
            errors++;
            if (errors <= 10)
                $display("%0t: mismatch: box %0d/%0d weighted %0d/%0d last %0b/%0b %s",
                         $realtime, want.box, i_box_mean, want.wmean, i_weighted_mean,
                         want.last, i_last, "(expected/actual)");
        end
    endfunction

    always @(posedge i_clk) begin : track
        int k;
        if (!i_rst_n) begin
            side_reg = CFG_W'(RST_SIDE);
            for (k = 0; k < MAX_SIDE; k++) begin
                row_older[k] = '0;
                row_newer[k] = '0;
            end
            for (k = 0; k < 9; k++) win[k] = '0;
            restart_image();
            smoothed_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                side_reg = i_cfg_data;
                restart_image();
            end
            if (i_in_valid && i_in_ready) filter_word(i_mode, i_pixel);
            if (i_out_valid && i_out_ready) check_result();
        end
        o_errors   <= errors;
        o_awaiting <= smoothed_q.size();
    end

endmodule

[sim/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dsf_pkg::*;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;
    localparam int   WATCHDOG   = 5000;
    localparam int   HOLD_LEN   = 400;
    localparam int   SETTLE     = 12;
    localparam int   ITEMS      = 1400;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CFG_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_ready;
    logic             i_mode;
    logic [PIX_W-1:0] i_pixel;
    logic             o_out_valid;
    logic             i_out_ready;
    logic [PIX_W-1:0] o_box_mean;
    logic [PIX_W-1:0] o_weighted_mean;
    logic             o_last;

    int   errors;
    int   awaiting;
    int   quiet_cycles = 0;
    logic steady;
    logic hold_off;

    dual_3x3_smoothing_filter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_pixel         (i_pixel),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_box_mean      (o_box_mean),
        .o_weighted_mean (o_weighted_mean),
        .o_last          (o_last)
    );

    smooth_check u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_pixel         (i_pixel),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_box_mean      (o_box_mean),
        .i_weighted_mean (o_weighted_mean),
        .i_last          (o_last),
        .o_errors        (errors),
        .o_awaiting      (awaiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Ends the run if no word of any channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : receiver
        int k;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                // Long hold-off so that the block fills up and stops taking words.
                i_out_ready <= 1'b0;
                for (k = 0; k < HOLD_LEN; k++) @(posedge i_clk);
                hold_off = 1'b0;
            end else begin
                i_out_ready <= steady || ($urandom_range(0, 99) >= 33);
            end
        end
    end

    task automatic send_word(input logic m, input logic [PIX_W-1:0] p);
        while (!steady && $urandom_range(0, 99) < 33) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= m;
        i_pixel    <= p;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic write_side(input logic [CFG_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Waits until every result is out, then lets the pipeline empty.
    task automatic finish_phase();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (awaiting != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // One image of side n: n*n pixels then n+1 drain words, stopped after cut words.
    task automatic send_image(input int n, input logic noisy, input int cut, inout int sent);
        int               k;
        logic [PIX_W-1:0] px;
        for (k = 0; k < n * n + n + 1 && k < cut; k++) begin
            if (k < n * n) begin
                if (noisy && $urandom_range(0, 9) == 0)
                    send_word(MODE_DRAIN, PIX_W'($urandom));
                case ($urandom_range(0, 9))
                    0:       px = '0;
                    1:       px = '1;
                    default: px = PIX_W'($urandom);
                endcase
                send_word(MODE_PIXEL, px);
            end else if (noisy && $urandom_range(0, 3) == 0) begin
                // A pixel word after the image counts as a drain word.
                send_word(MODE_PIXEL, PIX_W'($urandom));
            end else begin
                send_word(MODE_DRAIN, PIX_W'($urandom));
            end
            sent++;
        end
    endtask

    initial begin : stimulus
        int               sent;
        int               spare;
        int               phase;
        int               n;
        int               images;
        int               img;
        int               cut;
        logic [CFG_W-1:0] side_val;
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_mode      <= MODE_PIXEL;
        i_pixel     <= '0;
        hold_off = 1'b0;
        steady   = 1'b0;
        spare    = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Side after reset, part of one image, with no idling on either side.
        steady = 1'b1;
        send_image(RST_SIDE, 1'b0, RST_SIDE + 8, spare);
        finish_phase();
        steady = 1'b0;

        // Smallest image, all white.
        write_side('0);
        repeat (4) send_word(MODE_PIXEL, '1);
        repeat (3) send_word(MODE_DRAIN, '0);
        finish_phase();

        // Early drain, late pixel, then a second image straight after the first.
        write_side(CFG_W'(1));
        send_word(MODE_PIXEL, '0);
        send_word(MODE_DRAIN, '1);
        send_word(MODE_PIXEL, '1);
        send_word(MODE_PIXEL, '1);
        send_word(MODE_PIXEL, '0);
        send_word(MODE_PIXEL, 8'h5A);
        send_word(MODE_DRAIN, '0);
        send_word(MODE_DRAIN, 8'hA5);
        send_word(MODE_PIXEL, 8'h0F);
        send_word(MODE_PIXEL, 8'hF0);
        send_word(MODE_PIXEL, 8'h33);
        send_word(MODE_PIXEL, 8'hCC);
        repeat (3) send_word(MODE_DRAIN, '0);
        finish_phase();

        sent  = 0;
        phase = 0;
        while (spare + sent < ITEMS) begin
            case ($urandom_range(0, 9))
                0:       side_val = CFG_W'($urandom_range(0, 1));
                1, 2:    side_val = CFG_W'($urandom_range(9, 20));
                default: side_val = CFG_W'($urandom_range(2, 8));
            endcase
            // The hold-off phase needs an image large enough to back the block up.
            if (phase == 0) side_val = CFG_W'($urandom_range(9, 20));
            n = (side_val < 2) ? 2 : int'(side_val);
            write_side(side_val);
            if (phase == 0) hold_off = 1'b1;
            images = $urandom_range(1, 3);
            for (img = 0; img < images; img++) begin
                // Now and then the last image is cut short by the next side write.
                if (phase != 0 && img == images - 1 && $urandom_range(0, 5) == 0)
                    cut = $urandom_range(1, n * n + n);
                else
                    cut = n * n + n + 1;
                // The final image of the run stops once the word count is reached.
                if (cut > ITEMS - spare - sent)
                    cut = ITEMS - spare - sent;
                if (cut > 0)
                    send_image(n, $urandom_range(0, 4) == 0, cut, sent);
            end
            finish_phase();
            phase++;
        end

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
